/* rtl/wsti_pkg.sv */
// Shared types, constants and character class functions for the string to int64 converter.
`timescale 1ns / 1ps

package wsti_pkg;

    // Parse phase of the current string
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_BODY   = 3'd2,
        PH_ZERO   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    // Sequencer state
    typedef enum logic {
        SQ_IDLE = 1'b0,
        SQ_MAC  = 1'b1
    } t_seq;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_BADBASE = 2'd2
    } t_status;

    // Shift-add multiply steps, one per base bit
    localparam int unsigned MAC_STEPS = 6;
    localparam int unsigned PROD_W    = 71;
    localparam logic [6:0]  NOT_DIGIT = 7'd99;

    localparam logic [63:0] LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_NEG = 64'h8000_0000_0000_0000;

    localparam logic [15:0] CH_PLUS  = 16'h002B;
    localparam logic [15:0] CH_MINUS = 16'h002D;
    localparam logic [15:0] CH_LX    = 16'h0078;
    localparam logic [15:0] CH_UX    = 16'h0058;

    // Handshake and result between the sequencer and the multiply unit
    typedef struct packed {
        logic        done;
        logic        over;
        logic [63:0] acc;
    } t_mac_res;

    localparam logic [15:0] ZERO_POINTS [18] = '{
        16'h0030, 16'h0660, 16'h06F0, 16'h0966, 16'h09E6, 16'h0A66, 16'h0AE6,
        16'h0B66, 16'h0C66, 16'h0CE6, 16'h0D66, 16'h0E50, 16'h0ED0, 16'h0F20,
        16'h1040, 16'h17E0, 16'h1810, 16'hFF10
    };

    localparam logic [15:0] SPACE_POINTS [26] = '{
        16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h0020, 16'h0085,
        16'h00A0, 16'h1680, 16'h180E, 16'h2000, 16'h2001, 16'h2002, 16'h2003,
        16'h2004, 16'h2005, 16'h2006, 16'h2007, 16'h2008, 16'h2009, 16'h200A,
        16'h2028, 16'h2029, 16'h202F, 16'h205F, 16'h3000
    };

    function automatic logic is_space(input logic [15:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 26; i++) begin
            if (c == SPACE_POINTS[i]) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic is_zero(input logic [15:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 18; i++) begin
            if (c == ZERO_POINTS[i]) hit = 1'b1;
        end
        return hit;
    endfunction

    // Digit value 0..35, or NOT_DIGIT
    function automatic logic [6:0] digit_of(input logic [15:0] c);
        logic [6:0]  d;
        logic        found;
        logic [15:0] diff;
        d     = NOT_DIGIT;
        found = 1'b0;
        for (int i = 0; i < 18; i++) begin
            diff = c - ZERO_POINTS[i];
            if (!found && c >= ZERO_POINTS[i] && diff <= 16'd9) begin
                d     = 7'(diff);
                found = 1'b1;
            end
        end
        if (!found) begin
            if (c >= 16'h0061 && c <= 16'h007A) begin
                d = 7'(c - 16'h0057);
            end else if (c >= 16'h0041 && c <= 16'h005A) begin
                d = 7'(c - 16'h0037);
            end
        end
        return d;
    endfunction

endpackage

/* rtl/wide_string_to_int64.sv */
// Top level of the streaming UTF-16 string to signed 64-bit integer converter.
`timescale 1ns / 1ps

// Takes one UTF-16 code unit per request and returns one result
// (value, end offset, status) when the first non-digit, terminator included,
// ends the parse, or on the first unit of a string when the radix is invalid.
// A digit that is added to the accumulator goes through the shared shift-add
// unit, which walks the six bits of the base, one per cycle, and then
// compares the product against the sign-dependent limit. A new request is
// not taken while a result waits at the output. The radix register is
// sampled on the first unit of each string.
module wide_string_to_int64
    import wsti_pkg::*;
#(
    parameter logic [31:0] MAX_OFFSET = 32'd65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_code_unit,
    input  logic        i_string_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_value,
    output logic [15:0] o_end_offset,
    output logic [1:0]  o_status
);

    localparam logic [15:0] POS_LIMIT =
        (MAX_OFFSET > 32'd65535) ? 16'hFFFF : MAX_OFFSET[15:0];

    logic [5:0]  r_radix;
    t_phase      r_phase, n_phase;
    logic        r_neg, n_neg;
    logic [5:0]  r_base, n_base;
    logic [63:0] r_acc;
    logic        r_ovf, n_ovf;
    logic [15:0] r_pos, n_pos;
    logic        r_seen, n_seen;
    t_seq        r_seq, n_seq;

    logic        r_out_valid;
    logic [63:0] r_value;
    logic [15:0] r_end;
    logic [1:0]  r_status;

    logic        accept;
    logic        acc_clr;
    logic        emit;
    logic [63:0] e_value;
    logic [15:0] e_end;
    t_status     e_status;
    logic        mac_go;
    logic [5:0]  mac_digit;
    logic [63:0] acc_now;
    t_mac_res    mac_res;

    assign accept  = i_in_valid && o_in_ready;
    assign acc_now = acc_clr ? 64'd0 : r_acc;

    // Decode one code unit against the parse state
    always_comb begin
        logic       go_body;
        logic       go_feed;
        logic       adv;
        logic [6:0] d;
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_base    = r_base;
        n_ovf     = r_ovf;
        n_pos     = r_pos;
        n_seen    = r_seen;
        acc_clr   = 1'b0;
        emit      = 1'b0;
        e_value   = 64'd0;
        e_end     = 16'd0;
        e_status  = ST_OK;
        mac_go    = 1'b0;
        mac_digit = 6'd0;
        go_body   = 1'b0;
        go_feed   = 1'b0;
        adv       = 1'b0;
        d         = digit_of(i_code_unit);

        if (i_string_start) begin
            n_neg   = 1'b0;
            n_pos   = 16'd0;
            n_seen  = 1'b0;
            n_ovf   = 1'b0;
            acc_clr = 1'b1;
            if (r_radix != 6'd0 && (r_radix < 6'd2 || r_radix > 6'd36)) begin
                n_base   = 6'd0;
                n_phase  = PH_DONE;
                emit     = 1'b1;
                e_status = ST_BADBASE;
            end else begin
                n_base  = r_radix;
                n_phase = PH_LEAD;
            end
        end

        if (!emit) begin
            unique case (n_phase)
                PH_LEAD: begin
                    if (is_space(i_code_unit)) begin
                        adv = 1'b1;
                    end else if (i_code_unit == CH_PLUS || i_code_unit == CH_MINUS) begin
                        n_neg   = (i_code_unit == CH_MINUS);
                        n_phase = PH_BODY;
                        adv     = 1'b1;
                    end else begin
                        go_body = 1'b1;
                    end
                end
                PH_BODY: go_body = 1'b1;
                PH_ZERO: begin
                    if (i_code_unit == CH_LX || i_code_unit == CH_UX) begin
                        n_base  = 6'd16;
                        n_phase = PH_DIGITS;
                        adv     = 1'b1;
                    end else begin
                        if (n_base == 6'd0) n_base = 6'd8;
                        n_phase = PH_DIGITS;
                        n_seen  = 1'b1;
                        go_feed = 1'b1;
                    end
                end
                PH_DIGITS: go_feed = 1'b1;
                default: ;
            endcase

            // Base prefix check on the first body unit
            if (go_body) begin
                if ((n_base == 6'd0 || n_base == 6'd16) && is_zero(i_code_unit)) begin
                    n_phase = PH_ZERO;
                    adv     = 1'b1;
                end else begin
                    if (n_base == 6'd0) n_base = 6'd10;
                    n_phase = PH_DIGITS;
                    go_feed = 1'b1;
                end
            end

            // Take a digit or close the string
            if (go_feed) begin
                if (n_base < 6'd2 || n_base > 6'd36) n_base = 6'd10;
                if (d < {1'b0, n_base}) begin
                    n_seen    = 1'b1;
                    adv       = 1'b1;
                    mac_go    = !n_ovf;
                    mac_digit = d[5:0];
                end else begin
                    n_phase = PH_DONE;
                    emit    = 1'b1;
                    if (!n_seen) begin
                        e_value = 64'd0;
                    end else if (n_ovf) begin
                        e_value  = n_neg ? LIMIT_NEG : LIMIT_POS;
                        e_end    = n_pos;
                        e_status = ST_RANGE;
                    end else begin
                        e_value = n_neg ? (64'd0 - acc_now) : acc_now;
                        e_end   = n_pos;
                    end
                end
            end

            if (adv && n_pos < POS_LIMIT) n_pos = n_pos + 16'd1;
        end
    end

    // Sequencer next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_IDLE: if (accept && mac_go) n_seq = SQ_MAC;
            SQ_MAC:  if (mac_res.done) n_seq = SQ_IDLE;
            default: n_seq = SQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        unique case (r_seq)
            SQ_IDLE: o_in_ready = !r_out_valid;
            SQ_MAC:  o_in_ready = 1'b0;
            default: o_in_ready = 1'b0;
        endcase
    end

    // Radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= 6'd10;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_data;
        end
    end

    // Parse state and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= SQ_IDLE;
            r_phase <= PH_IDLE;
            r_neg   <= 1'b0;
            r_base  <= 6'd0;
            r_acc   <= 64'd0;
            r_ovf   <= 1'b0;
            r_pos   <= 16'd0;
            r_seen  <= 1'b0;
        end else begin
            r_seq <= n_seq;
            if (accept) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_base  <= n_base;
                r_acc   <= acc_now;
                r_ovf   <= n_ovf;
                r_pos   <= n_pos;
                r_seen  <= n_seen;
            end else if (mac_res.done) begin
                if (mac_res.over) r_ovf <= 1'b1;
                else              r_acc <= mac_res.acc;
            end
        end
    end

    // Result register: load on close, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_value  <= e_value;
            r_end    <= e_end;
            r_status <= e_status;
        end
    end

    wsti_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && mac_go),
        .i_acc   (acc_now),
        .i_base  (n_base),
        .i_digit (mac_digit),
        .i_limit (n_neg ? LIMIT_NEG : LIMIT_POS),
        .o_res   (mac_res)
    );

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_end_offset = r_end;
    assign o_status     = r_status;

    // No request is taken while the multiply unit works
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_MAC) |-> !o_in_ready)
        else $error("request taken during multiply");

    // The multiply unit reports only while the sequencer waits for it
    a_done_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_res.done |-> (r_seq == SQ_MAC))
        else $error("multiply done outside its slot");

    // An invalid base result carries neither value nor offset
    a_badbase_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_BADBASE) |-> (o_value == 64'd0 && o_end_offset == 16'd0))
        else $error("invalid base result not cleared");

    // A digit that starts the multiply moves the sequencer to wait for it
    a_start_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && mac_go) |=> (r_seq == SQ_MAC))
        else $error("sequencer missed a multiply start");

endmodule

/* rtl/wsti_mac.sv */
// Iterative shift-add multiply-accumulate with limit compare: acc * base + digit.
`timescale 1ns / 1ps

module wsti_mac
    import wsti_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_acc,
    input  logic [5:0]  i_base,
    input  logic [5:0]  i_digit,
    input  logic [63:0] i_limit,
    output t_mac_res    o_res
);

    logic                r_busy;
    logic                r_done;
    logic [2:0]          r_cnt;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   r_mcand;
    logic [5:0]          r_mult;
    logic [63:0]         r_limit;

    // Control: run one step per base bit, then flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'(MAC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: add the shifted multiplicand where the base bit is set
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod  <= PROD_W'(i_digit);
            r_mcand <= PROD_W'(i_acc);
            r_mult  <= i_base;
            r_limit <= i_limit;
        end else if (r_busy) begin
            if (r_mult[0]) r_prod <= r_prod + r_mcand;
            r_mcand <= r_mcand << 1;
            r_mult  <= r_mult >> 1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.over = (r_prod > PROD_W'(r_limit));
    assign o_res.acc  = r_prod[63:0];

endmodule

/* verif/wide_string_to_int64_tb.sv */
// Self-checking testbench for the streaming wide string to int64 converter.
`timescale 1ns / 1ps

module wide_string_to_int64_tb;
    import wsti_pkg::*;

    localparam int unsigned OFFSET_CAP  = 65535;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] end_offset;
        t_status     status;
    } t_conv_res;

    // Directed row: one code unit; a checked row carries its typed-in answer
    typedef struct {
        logic [15:0] unit;
        logic        first;
        logic        checked;
        t_conv_res   answer;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_code_unit;
    logic        i_string_start;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_value;
    logic [15:0] o_end_offset;
    logic [1:0]  o_status;

    wide_string_to_int64 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_code_unit    (i_code_unit),
        .i_string_start (i_string_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_value        (o_value),
        .o_end_offset   (o_end_offset),
        .o_status       (o_status)
    );

    // Predictor state
    logic [5:0]  m_radix;
    t_phase      m_phase;
    logic        m_neg;
    logic [5:0]  m_base;
    logic [63:0] m_acc;
    logic        m_over;
    logic [31:0] m_pos;
    logic        m_seen;

    t_conv_res   pending_results[$];
    t_conv_res   typed_answers[$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned units_sent;
    int unsigned cycles;
    logic        stim_done;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    function automatic logic space_unit(input logic [15:0] c);
        logic [15:0] pts [26];
        pts = '{16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h0020, 16'h0085,
                16'h00A0, 16'h1680, 16'h180E, 16'h2000, 16'h2001, 16'h2002, 16'h2003,
                16'h2004, 16'h2005, 16'h2006, 16'h2007, 16'h2008, 16'h2009, 16'h200A,
                16'h2028, 16'h2029, 16'h202F, 16'h205F, 16'h3000};
        foreach (pts[i]) if (c == pts[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [15:0] zero_block(input int i);
        logic [15:0] z [18];
        z = '{16'h0030, 16'h0660, 16'h06F0, 16'h0966, 16'h09E6, 16'h0A66, 16'h0AE6,
              16'h0B66, 16'h0C66, 16'h0CE6, 16'h0D66, 16'h0E50, 16'h0ED0, 16'h0F20,
              16'h1040, 16'h17E0, 16'h1810, 16'hFF10};
        return z[i];
    endfunction

    function automatic int unsigned value_of(input logic [15:0] c);
        for (int i = 0; i < 18; i++)
            if (c >= zero_block(i) && c - zero_block(i) <= 9) return c - zero_block(i);
        if (c >= "a" && c <= "z") return c - "a" + 10;
        if (c >= "A" && c <= "Z") return c - "A" + 10;
        return 99;
    endfunction

    function automatic logic zero_unit(input logic [15:0] c);
        for (int i = 0; i < 18; i++) if (c == zero_block(i)) return 1'b1;
        return 1'b0;
    endfunction

    task automatic bump_pos();
        if (m_pos < OFFSET_CAP) m_pos++;
    endtask

    task automatic take_digit(input int unsigned d);
        logic [63:0] lim;
        lim = m_neg ? LIMIT_NEG : LIMIT_POS;
        m_seen = 1'b1;
        if (m_over) return;
        if (m_acc > lim / m_base || (m_acc == lim / m_base && d > lim % m_base))
            m_over = 1'b1;
        else
            m_acc = m_acc * m_base + d;
    endtask

    task automatic close_or_digit(input logic [15:0] c);
        int unsigned d;
        t_conv_res r;
        d = value_of(c);
        if (m_base < 2 || m_base > 36) m_base = 6'd10;
        if (d < m_base) begin
            take_digit(d);
            bump_pos();
            return;
        end
        m_phase = PH_DONE;
        if (!m_seen) r = '{64'd0, 16'd0, ST_OK};
        else if (m_over) r = '{m_neg ? LIMIT_NEG : LIMIT_POS, m_pos[15:0], ST_RANGE};
        else r = '{m_neg ? 64'd0 - m_acc : m_acc, m_pos[15:0], ST_OK};
        pending_results.push_back(r);
    endtask

    task automatic body_unit(input logic [15:0] c);
        if ((m_base == 0 || m_base == 16) && zero_unit(c)) begin
            m_phase = PH_ZERO;
            bump_pos();
            return;
        end
        if (m_base == 0) m_base = 6'd10;
        m_phase = PH_DIGITS;
        close_or_digit(c);
    endtask

    // Advance the predictor by one accepted code unit
    task automatic predict_unit(input logic [15:0] c, input logic first);
        if (first) begin
            m_neg = 0; m_acc = 0; m_over = 0; m_pos = 0; m_seen = 0;
            if (m_radix != 0 && (m_radix < 2 || m_radix > 36)) begin
                m_base = 0;
                m_phase = PH_DONE;
                pending_results.push_back('{64'd0, 16'd0, ST_BADBASE});
                return;
            end
            m_base = m_radix;
            m_phase = PH_LEAD;
        end
        case (m_phase)
            PH_LEAD: begin
                if (space_unit(c)) bump_pos();
                else if (c == CH_MINUS || c == CH_PLUS) begin
                    m_neg = (c == CH_MINUS);
                    m_phase = PH_BODY;
                    bump_pos();
                end else body_unit(c);
            end
            PH_BODY: body_unit(c);
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    m_base = 6'd16;
                    m_phase = PH_DIGITS;
                    bump_pos();
                end else begin
                    if (m_base == 0) m_base = 6'd8;
                    m_phase = PH_DIGITS;
                    take_digit(0);
                    close_or_digit(c);
                end
            end
            PH_DIGITS: close_or_digit(c);
            default: ;
        endcase
    endtask

    // Offer one code unit after a random gap and hold until accepted
    task automatic send_unit(input logic [15:0] c, input logic first);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_code_unit    <= c;
        i_string_start <= first;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_unit(c, first);
        units_sent++;
    endtask

    // Write the radix while idle
    task automatic set_radix(input logic [5:0] r);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_radix = r;
    endtask

    // Accept and check results with random back-pressure
    initial begin
        t_conv_res got, want, typed;
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got = '{o_value, o_end_offset, t_status'(o_status)};
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value)
                    report_mismatch($sformatf("value %h want %h", got.value, want.value));
                if (got.end_offset !== want.end_offset)
                    report_mismatch($sformatf("end_offset %0d want %0d",
                                              got.end_offset, want.end_offset));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
                if (typed_answers.size() != 0 && !stim_done) begin
                    typed = typed_answers.pop_front();
                    if (typed.status != ST_OK || typed.value != 64'd1) begin
                        if (got !== typed)
                            report_mismatch($sformatf("directed %h want %h", got, typed));
                    end
                end
            end
        end
    end

    // Random string: mostly well-formed numbers, some noise
    task automatic random_string();
        int n, kind;
        logic [15:0] c;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // noise including full-range units and stray non-start units
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_unit(16'($urandom()), i == 0 ? 1'b1 : 1'($urandom_range(0, 1)));
            send_unit(16'h0000, 1'b0);
            return;
        end
        n = $urandom_range(0, 2);
        send_unit(n != 0 ? 16'h0020 : ($urandom_range(0, 1) ? CH_MINUS : CH_PLUS), 1'b1);
        for (int i = 1; i < n; i++) send_unit(16'h3000, 1'b0);
        if ($urandom_range(0, 2) == 0) send_unit(zero_block($urandom_range(0, 17)), 1'b0);
        if ($urandom_range(0, 3) == 0) send_unit($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
        n = $urandom_range(0, 24);
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 3);
            if (kind == 0) c = 16'($urandom_range("a", "z"));
            else if (kind == 1) c = 16'($urandom_range("A", "Z"));
            else c = zero_block($urandom_range(0, 17)) + 16'($urandom_range(0, 9));
            send_unit(c, 1'b0);
        end
        // abandon sometimes by restarting, else terminate
        if ($urandom_range(0, 15) != 0)
            send_unit($urandom_range(0, 1) ? 16'h0000 : 16'($urandom()), 1'b0);
    endtask

    // Stimulus
    initial begin
        t_row rows[$];
        logic [5:0] radices[8];
        errors = 0; results_seen = 0; units_sent = 0; cycles = 0; stim_done = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_code_unit = '0; i_string_start = 1'b0;
        m_radix = 6'd10; m_phase = PH_IDLE; m_neg = 0; m_base = 0;
        m_acc = 0; m_over = 0; m_pos = 0; m_seen = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Stray unit before any string, then "-9" checked, a lone non-digit unit
        // checked as no digits, then unchecked predictor rows
        rows = '{
            '{16'h0031, 1'b0, 1'b0, '{64'd1, 16'd0, ST_OK}},
            '{CH_MINUS, 1'b1, 1'b0, '{64'd1, 16'd0, ST_OK}},
            '{16'h0039, 1'b0, 1'b0, '{64'd1, 16'd0, ST_OK}},
            '{16'h0000, 1'b0, 1'b1, '{-64'sd9, 16'd2, ST_OK}},
            '{16'hFFFF, 1'b1, 1'b1, '{64'd0, 16'd0, ST_OK}},
            '{16'h0020, 1'b1, 1'b0, '{64'd1, 16'd0, ST_OK}},
            '{16'hFF19, 1'b0, 1'b0, '{64'd1, 16'd0, ST_OK}},
            '{16'h0E59, 1'b0, 1'b0, '{64'd1, 16'd0, ST_OK}},
            '{16'h002E, 1'b0, 1'b0, '{64'd1, 16'd0, ST_OK}}
        };
        foreach (rows[i]) begin
            if (rows[i].checked) typed_answers.push_back(rows[i].answer);
            else if (rows[i].first || rows[i].unit == 16'h002E)
                ; // predictor only
            send_unit(rows[i].unit, rows[i].first);
        end
        // overflow both signs in base 10
        send_unit(16'h0039, 1'b1);
        repeat (20) send_unit(16'h0039, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(CH_MINUS, 1'b1);
        repeat (20) send_unit(16'h0039, 1'b0);
        send_unit(16'h0000, 1'b0);

        // Radix extremes, invalid bases, auto detect and prefix cases
        radices = '{6'd0, 6'd1, 6'd2, 6'd16, 6'd36, 6'd37, 6'd63, 6'd8};
        foreach (radices[k]) begin
            set_radix(radices[k]);
            send_unit(zero_block(k), 1'b1);
            send_unit(CH_LX, 1'b0);
            send_unit(16'h0000, 1'b0);
            send_unit(16'h0030, 1'b1);
            send_unit(16'h0037, 1'b0);
            send_unit(16'h0000, 1'b0);
        end

        // Random part across several settings
        for (int p = 0; p < 10; p++) begin
            set_radix(p == 0 ? 6'd0 : p == 1 ? 6'd36 : p == 2 ? 6'd2 :
                      6'($urandom_range(0, 63)));
            while (units_sent < 120 + p * 85) random_string();
        end
        set_radix(6'd10);
        while (units_sent < 950) random_string();

        stim_done = 1;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("sent %0d code units, checked %0d results across radix settings",
                 units_sent, results_seen);
        $display("covered invalid bases, prefixes, saturation of both signs and restarts");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
